@@ sv/utf8_byte_stream_decoder_top_assert.svh @@
// Assertion macros for the UTF-8 byte stream decoder checker.
`ifndef UTF8_BYTE_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_TOP_ASSERT_SVH

// Clocked property, quiet while reset is high.
`define U8D_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication built on the plain form.
`define U8D_ASSERT_IMPL(label, ante, cons, msg) \
  `U8D_ASSERT_PROP(label, (ante) |-> (cons), msg)

// Next-cycle implication built on the plain form.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  `U8D_ASSERT_PROP(label, (ante) |=> (cons), msg)

`endif

@@ sv/u8d_pkg.sv @@
// Shared types, constants and check helpers for the UTF-8 byte stream decoder.
`timescale 1ns / 1ps
package u8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int SEQ_W  = 3;
  localparam int DUE_W  = 3;
  localparam int ERR_W  = 3;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [CP_W-1:0]  MAX_SCALAR = 21'h10FFFF;
  localparam logic [CP_W-1:0]  SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0]  SURR_HI    = 21'h00DFFF;
  localparam logic [1:0]       CONT_TAG   = 2'b10;
  // Sequence index from which a form is always overlong (5 to 8 byte leads).
  localparam logic [SEQ_W-1:0] LONG_FORM_IDX = 3'd3;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_STRAY     = 3'd1,
    ERR_OVERRUN   = 3'd2,
    ERR_MISSING   = 3'd3,
    ERR_OVERLONG  = 3'd4,
    ERR_RANGE     = 3'd5,
    ERR_SURROGATE = 3'd6
  } err_t;

  // One finished sequence on its way from front to back.
  typedef struct packed {
    logic             check;      // value still needs the final checks
    err_t             err;        // error already known when check is low
    logic [SEQ_W-1:0] seq_index;  // continuation count minus one
    logic [CP_W-1:0]  cp;
  } u8d_rec_t;

  // Smallest legal value for 2, 3 and 4 byte forms.
  function automatic logic [CP_W-1:0] min_scalar(input logic [SEQ_W-1:0] idx);
    logic [CP_W-1:0] m;
    case (idx)
      3'd0:    m = 21'h000080;
      3'd1:    m = 21'h000800;
      3'd2:    m = 21'h010000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ sv/u8d_front.sv @@
// Front end: accepts bytes, tracks sequence state, emits finished sequences.
`timescale 1ns / 1ps
module u8d_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_ready,
  input  logic [u8d_pkg::BYTE_W-1:0]   byte_in,
  input  logic                         buffer_last,
  input  logic                         q_full,
  output logic                         push,
  output u8d_pkg::u8d_rec_t            push_rec
);
  import u8d_pkg::*;

  logic [DUE_W-1:0] bytes_due, bytes_due_next;
  logic [SEQ_W-1:0] sequence_index, sequence_index_next;
  logic [CP_W-1:0]  accumulator, accumulator_next;
  logic             accept;
  logic [DUE_W-1:0] lead_due;
  logic [DUE_W-1:0] cont_due;
  logic [CP_W-1:0]  lead_acc;
  logic [CP_W-1:0]  cont_acc;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  // Continuation count announced by a lead byte
  always_comb begin
    if (!byte_in[5]) begin
      lead_due = 3'd1;
    end else if (!byte_in[4]) begin
      lead_due = 3'd2;
    end else if (!byte_in[3]) begin
      lead_due = 3'd3;
    end else if (!byte_in[2]) begin
      lead_due = 3'd4;
    end else if (!byte_in[1]) begin
      lead_due = 3'd5;
    end else if (!byte_in[0]) begin
      lead_due = 3'd6;
    end else begin
      lead_due = 3'd7;
    end
  end

  // Payload bits of the lead; long forms gather nothing
  always_comb begin
    case (lead_due)
      3'd1:    lead_acc = {{(CP_W-5){1'b0}}, byte_in[4:0]};
      3'd2:    lead_acc = {{(CP_W-4){1'b0}}, byte_in[3:0]};
      3'd3:    lead_acc = {{(CP_W-3){1'b0}}, byte_in[2:0]};
      default: lead_acc = '0;
    endcase
  end

  assign cont_acc = {accumulator[CP_W-7:0], byte_in[5:0]};
  assign cont_due = bytes_due - 3'd1;

  // Next state and finished-sequence record
  always_comb begin
    bytes_due_next      = bytes_due;
    sequence_index_next = sequence_index;
    accumulator_next    = accumulator;
    push                = 1'b0;
    push_rec            = '0;
    push_rec.err        = ERR_NONE;
    if (accept) begin
      if (bytes_due == '0) begin
        if (!byte_in[7]) begin
          push        = 1'b1;
          push_rec.cp = {{(CP_W-BYTE_W){1'b0}}, byte_in};
        end else if (!byte_in[6]) begin
          push         = 1'b1;
          push_rec.err = ERR_STRAY;
        end else begin
          sequence_index_next = lead_due - 3'd1;
          accumulator_next    = lead_acc;
          if (buffer_last) begin
            bytes_due_next = '0;
            push           = 1'b1;
            push_rec.err   = ERR_OVERRUN;
          end else begin
            bytes_due_next = lead_due;
          end
        end
      end else if (byte_in[7:6] != CONT_TAG) begin
        bytes_due_next = '0;
        push           = 1'b1;
        push_rec.err   = ERR_MISSING;
      end else begin
        accumulator_next = cont_acc;
        bytes_due_next   = cont_due;
        if (cont_due != '0) begin
          if (buffer_last) begin
            bytes_due_next = '0;
            push           = 1'b1;
            push_rec.err   = ERR_OVERRUN;
          end
        end else begin
          push               = 1'b1;
          push_rec.check     = 1'b1;
          push_rec.seq_index = sequence_index;
          push_rec.cp        = cont_acc;
        end
      end
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_due      <= '0;
      sequence_index <= '0;
      accumulator    <= '0;
    end else begin
      bytes_due      <= bytes_due_next;
      sequence_index <= sequence_index_next;
      accumulator    <= accumulator_next;
    end
  end

endmodule

@@ sv/u8d_queue.sv @@
// Short FIFO of finished sequences between front and back.
`timescale 1ns / 1ps
module u8d_queue #(
  parameter int DEPTH = u8d_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8d_pkg::u8d_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output u8d_pkg::u8d_rec_t pop_rec
);
  import u8d_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8d_rec_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;
  assign pop_rec = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/u8d_back.sv @@
// Back end: final range checks and the result output register.
`timescale 1ns / 1ps
module u8d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  u8d_pkg::u8d_rec_t           pop_rec,
  output logic                        pop,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [u8d_pkg::CP_W-1:0]    code_point,
  output logic [u8d_pkg::ERR_W-1:0]   error
);
  import u8d_pkg::*;

  err_t            chk_err;
  err_t            fin_err;
  logic [CP_W-1:0] fin_cp;

  assign pop = q_valid && (!result_valid || result_ready);

  // Overlong, range and surrogate checks, in that order
  always_comb begin
    if (pop_rec.seq_index >= LONG_FORM_IDX || pop_rec.cp < min_scalar(pop_rec.seq_index)) begin
      chk_err = ERR_OVERLONG;
    end else if (pop_rec.cp > MAX_SCALAR) begin
      chk_err = ERR_RANGE;
    end else if (pop_rec.cp >= SURR_LO && pop_rec.cp <= SURR_HI) begin
      chk_err = ERR_SURROGATE;
    end else begin
      chk_err = ERR_NONE;
    end
  end

  assign fin_err = pop_rec.check ? chk_err : pop_rec.err;
  assign fin_cp  = (fin_err == ERR_NONE) ? pop_rec.cp : '0;

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      code_point <= fin_cp;
      error      <= ERR_W'(fin_err);
    end
  end

endmodule

@@ sv/utf8_byte_stream_decoder_top.sv @@
// Top level of the UTF-8 byte stream decoder.
// Usage:
//   Byte channel: byte_valid/byte_ready with byte_in and buffer_last, one byte per
//   transaction; buffer_last marks the final byte of a buffer.
//   Result channel: result_valid/result_ready with code_point and error, one
//   transaction per finished sequence (ASCII byte, completed multi-byte form,
//   or error). code_point is zero whenever error is nonzero.
// Result path: the front updates the sequence state and queues the result at the
//   edge that accepts the byte ending its sequence; the back then checks it and
//   loads the output register when that register is empty or being taken.
// Throughput: one byte per cycle while the queue has room, as the front updates
//   its accumulator per byte; bytes that only extend a sequence produce no result.
// Stalls: while result_ready is low, finished sequences collect in a queue of
//   QUEUE_DEPTH entries; byte_ready drops only when that queue is full.
// Reset: rst is synchronous; it returns the decoder to idle, empties the queue
//   and drops result_valid. No result is pending after reset.
`timescale 1ns / 1ps
module utf8_byte_stream_decoder_top #(
  parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_ready,
  input  logic [u8d_pkg::BYTE_W-1:0]  byte_in,
  input  logic                        buffer_last,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [u8d_pkg::CP_W-1:0]    code_point,
  output logic [u8d_pkg::ERR_W-1:0]   error
);
  import u8d_pkg::*;

  logic     q_full;
  logic     push;
  logic     pop;
  logic     q_valid;
  u8d_rec_t push_rec;
  u8d_rec_t pop_rec;

  // Byte intake and sequence tracking
  u8d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_in     (byte_in),
    .buffer_last (buffer_last),
    .q_full      (q_full),
    .push        (push),
    .push_rec    (push_rec)
  );

  // Decoupling queue
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_rec  (pop_rec)
  );

  // Checks and output register
  u8d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .pop_rec      (pop_rec),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .code_point   (code_point),
    .error        (error)
  );

endmodule

@@ sv/u8d_checker.sv @@
// Port-level checker for the UTF-8 byte stream decoder, bound to the top level.
`timescale 1ns / 1ps
`include "utf8_byte_stream_decoder_top_assert.svh"
module u8d_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        byte_valid,
  input logic                        byte_ready,
  input logic [u8d_pkg::BYTE_W-1:0]  byte_in,
  input logic                        buffer_last,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [u8d_pkg::CP_W-1:0]    code_point,
  input logic [u8d_pkg::ERR_W-1:0]   error
);
  import u8d_pkg::*;

  logic ok_result;
  logic err_result;
  logic scalar_legal;
  logic byte_seen;

  assign ok_result    = result_valid && (error == ERR_W'(ERR_NONE));
  assign err_result   = result_valid && (error != ERR_W'(ERR_NONE));
  assign scalar_legal = (code_point <= MAX_SCALAR) &&
                        !((code_point >= SURR_LO) && (code_point <= SURR_HI));
  assign byte_seen    = byte_valid || byte_ready || buffer_last || (byte_in != '0);

  // An error transaction never carries a value
  `U8D_ASSERT_IMPL(a_err_zero_cp, err_result, code_point == '0, "error result with nonzero code_point")

  // A good transaction is always a Unicode scalar value
  `U8D_ASSERT_IMPL(a_ok_scalar, ok_result, scalar_legal || !byte_seen && scalar_legal, "good result outside scalar range")

  // A stalled result stays put
  `U8D_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(code_point) && $stable(error), "result changed while stalled")

endmodule

bind utf8_byte_stream_decoder_top u8d_checker u_u8d_checker (.*);
